// File: hw/rtl/lexbuf_pkg.sv
// ----------------------------------------------------------------------------
// lexbuf_pkg
// Shared types, codes and sizes for the lexer input character buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package lexbuf_pkg;

  // Sizes
  localparam int MAX_CAPACITY = 4096;
  localparam int CHAR_BINS    = 128;
  localparam int POS_W        = 13;                   // holds 0..MAX_CAPACITY
  localparam int ADDR_W       = $clog2(MAX_CAPACITY); // store address
  localparam int BIN_W        = $clog2(CHAR_BINS);    // histogram address
  localparam int CHAR_W       = 7;
  localparam int CNT_W        = 13;
  localparam int SUM_W        = 8;
  localparam int INC_W        = 8;
  localparam int MODE_W       = 2;
  localparam int KIND_W       = 4;
  localparam int CHV_W        = 8;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int GROW_W       = POS_W + INC_W;        // capacity times factor

  localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;
  localparam logic [POS_W-1:0]  CAP_MAX       = POS_W'(MAX_CAPACITY);
  localparam logic [POS_W-1:0]  CAP_RESET     = 13'd256;
  localparam logic [INC_W-1:0]  INC_RESET     = 8'd10;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ADD      = 4'd0;
  localparam logic [KIND_W-1:0] KIND_GET      = 4'd1;
  localparam logic [KIND_W-1:0] KIND_RETRACT  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_SET_MARK = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RESTORE  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RECOVER  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_HIST     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_READ_AT  = 4'd8;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_DATA  = 2'd3;

  // Growth modes
  localparam logic [MODE_W-1:0] GROW_FIXED    = 2'd0;
  localparam logic [MODE_W-1:0] GROW_ADD      = 2'd1;
  localparam logic [MODE_W-1:0] GROW_MUL      = 2'd2;
  localparam logic [MODE_W-1:0] GROW_JUMP     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_INC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHV_W-1:0]  char_value;
    logic [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   data_char;
    logic                at_end;
    logic                is_full;
    logic                is_empty;
    logic [POS_W-1:0]    read_pos;
    logic [POS_W-1:0]    write_pos;
    logic [POS_W-1:0]    mark_pos;
    logic [POS_W-1:0]    capacity;
    logic [SUM_W-1:0]    checksum;
    logic [CNT_W-1:0]    char_count;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/lexbuf_ram.sv
// ----------------------------------------------------------------------------
// lexbuf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lexbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lexer_input_char_buffer.sv
// ----------------------------------------------------------------------------
// lexer_input_char_buffer
// Growable character buffer with read, write and mark positions, histogram
// and running checksum.
// ----------------------------------------------------------------------------
// Each operation goes from input transfer to a registered result as follows:
// the transfer cycle issues the reads of the character RAM and the histogram
// RAM, then S_EXEC modifies the state, writes back and loads the output
// register. The registered RAM reads put S_EXEC between the transfer and the
// result, and no new item is taken until S_EXEC has committed the last one;
// a stalled output holds S_EXEC until the output register frees up.
// The histogram needs no clearing pass after reset: a valid bit per bin makes
// an unwritten bin read as zero. Configuration writes are taken only while no
// item is executing.
`default_nettype none

module lexer_input_char_buffer
  import lexbuf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  // results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [POS_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  // Architectural state
  logic [POS_W-1:0]  write_position, read_position, mark_position;
  logic [POS_W-1:0]  current_capacity;
  logic [SUM_W-1:0]  running_sum;
  logic              flag_full, end_hit;
  logic [MODE_W-1:0] growth_mode;
  logic [INC_W-1:0]  growth_increment;
  logic [CHAR_BINS-1:0] hist_valid;

  // Item in flight
  in_item_t item;
  logic     hist_hit;

  logic in_fire, cfg_fire, commit;

  // RAM ports
  logic                store_we, hist_we;
  logic [ADDR_W-1:0]   store_raddr;
  logic [CHAR_W-1:0]   store_rdata;
  logic [CNT_W-1:0]    hist_rdata;
  logic [CNT_W-1:0]    hist_wdata;

  // Next state
  logic [POS_W-1:0]    write_position_next, read_position_next, mark_position_next;
  logic [POS_W-1:0]    current_capacity_next;
  logic [SUM_W-1:0]    running_sum_next;
  logic                flag_full_next, end_hit_next;
  logic [STATUS_W-1:0] res_status;
  logic [CHAR_W-1:0]   res_data;
  logic [CNT_W-1:0]    res_count;
  logic                do_store;

  // Growth and histogram arithmetic
  logic [GROW_W-1:0]   grown;
  logic                grow_ok;
  logic [CNT_W-1:0]    hist_cur;
  logic [POS_W-1:0]    cfg_cap;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign commit    = (state == S_EXEC) && (!out_valid || out_ready);

  // Read address chosen at the transfer
  assign store_raddr = (in_data.kind == KIND_GET) ? read_position[ADDR_W-1:0]
                                                  : in_data.position[ADDR_W-1:0];

  lexbuf_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (write_position[ADDR_W-1:0]),
    .wr_data (item.char_value[CHAR_W-1:0]),
    .rd_en   (in_fire),
    .rd_addr (store_raddr),
    .rd_data (store_rdata)
  );

  lexbuf_ram #(.WIDTH(CNT_W), .DEPTH(CHAR_BINS)) u_hist (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (item.char_value[BIN_W-1:0]),
    .wr_data (hist_wdata),
    .rd_en   (in_fire),
    .rd_addr (in_data.char_value[BIN_W-1:0]),
    .rd_data (hist_rdata)
  );

  // Candidate capacity on overflow
  always_comb begin
    case (growth_mode)
      GROW_ADD: grown = GROW_W'(current_capacity) + GROW_W'(growth_increment);
      GROW_MUL: grown = GROW_W'(current_capacity) * GROW_W'(growth_increment);
      GROW_JUMP: grown = GROW_W'(CAP_MAX);
      default: grown = GROW_W'(current_capacity);
    endcase
    grow_ok = (grown > GROW_W'(current_capacity)) && (grown > GROW_W'(write_position))
           && (grown <= GROW_W'(CAP_MAX));
  end

  // Saturating histogram increment
  assign hist_cur   = hist_hit ? hist_rdata : '0;
  assign hist_wdata = (hist_cur != COUNT_MAX) ? hist_cur + 1'b1 : hist_cur;

  // Operation execute
  always_comb begin
    write_position_next   = write_position;
    read_position_next    = read_position;
    mark_position_next    = mark_position;
    current_capacity_next = current_capacity;
    running_sum_next      = running_sum;
    flag_full_next        = flag_full;
    end_hit_next          = end_hit;
    res_status            = ST_OK;
    res_data              = '0;
    res_count             = '0;
    do_store              = 1'b0;

    unique case (item.kind)
      KIND_ADD: begin
        if (item.char_value[CHV_W-1]) begin
          res_status = ST_INVALID;
        end else if (write_position < current_capacity) begin
          do_store = 1'b1;
        end else if (growth_mode == GROW_FIXED) begin
          flag_full_next = 1'b1;
          res_status     = ST_FULL;
        end else if (grow_ok) begin
          current_capacity_next = grown[POS_W-1:0];
          do_store              = 1'b1;
        end else begin
          res_status = ST_INVALID;
        end
        if (do_store) begin
          write_position_next = write_position + 1'b1;
          flag_full_next      = (write_position_next == current_capacity_next);
          running_sum_next    = running_sum + SUM_W'(item.char_value[CHAR_W-1:0]);
        end
      end
      KIND_GET: begin
        if (read_position >= write_position) begin
          end_hit_next = 1'b1;
          res_status   = ST_NO_DATA;
        end else begin
          end_hit_next       = 1'b0;
          res_data           = store_rdata;
          read_position_next = read_position + 1'b1;
        end
      end
      KIND_RETRACT: begin
        if (read_position != '0) begin
          read_position_next = read_position - 1'b1;
        end else begin
          res_status = ST_NO_DATA;
        end
      end
      KIND_SET_MARK: begin
        if (item.position > write_position) begin
          res_status = ST_NO_DATA;
        end else begin
          mark_position_next = item.position;
        end
      end
      KIND_RESTORE: begin
        if (mark_position <= write_position) begin
          read_position_next = mark_position;
        end else begin
          res_status = ST_NO_DATA;
        end
      end
      KIND_CLEAR: begin
        write_position_next = '0;
        read_position_next  = '0;
        mark_position_next  = '0;
        running_sum_next    = '0;
        flag_full_next      = 1'b0;
        end_hit_next        = 1'b0;
      end
      KIND_RECOVER: begin
        read_position_next = '0;
        mark_position_next = '0;
        flag_full_next     = 1'b0;
      end
      KIND_HIST: begin
        if (item.char_value[CHV_W-1]) begin
          res_status = ST_INVALID;
        end else begin
          res_count = hist_cur;
        end
      end
      KIND_READ_AT: begin
        if (item.position < write_position) begin
          res_data = store_rdata;
        end else begin
          res_status = ST_NO_DATA;
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  assign store_we = commit && do_store;
  assign hist_we  = commit && do_store;

  // Capacity register write, clamped to 1..MAX_CAPACITY
  always_comb begin
    if (cfg_data == '0) begin
      cfg_cap = POS_W'(1);
    end else if (cfg_data > CAP_MAX) begin
      cfg_cap = CAP_MAX;
    end else begin
      cfg_cap = cfg_data;
    end
  end

  // Sequencer and item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) state <= S_EXEC;
        S_EXEC: if (commit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item     <= in_data;
      hist_hit <= hist_valid[in_data.char_value[BIN_W-1:0]];
    end
  end

  // State update and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position   <= '0;
      read_position    <= '0;
      mark_position    <= '0;
      current_capacity <= CAP_RESET;
      running_sum      <= '0;
      flag_full        <= 1'b0;
      end_hit          <= 1'b0;
      growth_mode      <= GROW_FIXED;
      growth_increment <= INC_RESET;
      hist_valid       <= '0;
    end else begin
      if (commit) begin
        write_position   <= write_position_next;
        read_position    <= read_position_next;
        mark_position    <= mark_position_next;
        current_capacity <= current_capacity_next;
        running_sum      <= running_sum_next;
        flag_full        <= flag_full_next;
        end_hit          <= end_hit_next;
        if (do_store) begin
          hist_valid[item.char_value[BIN_W-1:0]] <= 1'b1;
        end
      end
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_GROWTH_MODE: growth_mode      <= cfg_data[MODE_W-1:0];
          REG_GROWTH_INC:  growth_increment <= cfg_data[INC_W-1:0];
          REG_INIT_CAP:    current_capacity <= cfg_cap;
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.status     <= res_status;
      out_data.data_char  <= res_data;
      out_data.at_end     <= end_hit_next;
      out_data.is_full    <= flag_full_next;
      out_data.is_empty   <= (write_position_next == '0);
      out_data.read_pos   <= read_position_next;
      out_data.write_pos  <= write_position_next;
      out_data.mark_pos   <= mark_position_next;
      out_data.capacity   <= current_capacity_next;
      out_data.checksum   <= running_sum_next;
      out_data.char_count <= res_count;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lexbuf_checker.sv
// ----------------------------------------------------------------------------
// lexbuf_checker
// Port-level checks for the lexer input character buffer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lexbuf_checker
  import lexbuf_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire in_item_t             in_data,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire out_item_t            out_data,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [POS_W-1:0]     cfg_data
);

  // A held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Read and mark positions never pass the write position
  a_pos_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.read_pos <= out_data.write_pos) &&
                  (out_data.mark_pos <= out_data.write_pos))
    else $error("read or mark position beyond write position");

  // Capacity stays within 1..MAX_CAPACITY
  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.capacity != '0) && (out_data.capacity <= CAP_MAX))
    else $error("capacity out of range");

  // Empty flag tracks the write position
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_empty == (out_data.write_pos == '0)))
    else $error("empty flag disagrees with write position");

endmodule

bind lexer_input_char_buffer lexbuf_checker u_lexbuf_checker (.*);

`default_nettype wire
